// ----- hw/rtl/elsm_pkg.sv -----
// ============================================================================
// elsm_pkg
// Shared types and constants of the event latency statistics monitor.
// ============================================================================
package elsm_pkg;

  // Timer ticks per millisecond and PCM bytes per millisecond (powers of two)
  localparam int unsigned TicksPerMs = 16;
  localparam int unsigned BytesPerMs = 32;
  localparam int unsigned TickShift  = $clog2(TicksPerMs);
  localparam int unsigned ByteShift  = $clog2(BytesPerMs);
  localparam int unsigned ClampMs    = 60000;

  localparam int unsigned NumAcc   = 7;
  localparam int unsigned NumStamp = 5;
  localparam int unsigned NumCnt   = 4;
  localparam int unsigned NumPend  = 4;

  typedef logic [2:0] acc_idx_t;
  typedef logic [2:0] slot_idx_t;
  typedef logic [1:0] cnt_idx_t;

  // Start stamp slots; slots 0..3 also own a pending bit
  localparam slot_idx_t SlotCapture = 3'd0;
  localparam slot_idx_t SlotExtraQ  = 3'd1;
  localparam slot_idx_t SlotExtraBt = 3'd2;
  localparam slot_idx_t SlotCmdQ    = 3'd3;
  localparam slot_idx_t SlotRecv    = 3'd4;

  // Accumulators
  localparam acc_idx_t AccCapSend = 3'd0;
  localparam acc_idx_t AccExtraBt = 3'd1;
  localparam acc_idx_t AccBtTx    = 3'd2;
  localparam acc_idx_t AccCmd     = 3'd3;
  localparam acc_idx_t AccRecvPut = 3'd4;
  localparam acc_idx_t AccRxBuf   = 3'd5;
  localparam acc_idx_t AccPlayBuf = 3'd6;

  // Event counters
  localparam cnt_idx_t CntExtra    = 2'd0;
  localparam cnt_idx_t CntCmd      = 2'd1;
  localparam cnt_idx_t CntUnderrun = 2'd2;
  localparam cnt_idx_t CntTxFail   = 2'd3;

  // Read index codes: last accumulator code, first and last counter codes
  localparam logic [3:0] ReadCntBase = 4'd7;
  localparam logic [3:0] ReadCntLast = 4'd10;
  localparam logic [3:0] ReadAccLast = 4'd6;

  typedef enum logic [3:0] {
    REQ_CAPTURE_DONE = 4'd0,
    REQ_SEND_BEGIN   = 4'd1,
    REQ_EXTRA_QUEUED = 4'd2,
    REQ_BT_SENT      = 4'd3,
    REQ_TX_HANDLED   = 4'd4,
    REQ_CMD_DONE     = 4'd5,
    REQ_RECV_BEGIN   = 4'd6,
    REQ_RECV_PUT     = 4'd7,
    REQ_PLAY_OK      = 4'd8,
    REQ_UNDERRUN     = 4'd9,
    REQ_CLEAR        = 4'd10,
    REQ_READ         = 4'd11
  } elsm_req_e;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] now_ticks;
    logic        event_flag;
    logic [31:0] buffer_bytes;
    logic [3:0]  stat_index;
  } elsm_req_t;

  typedef struct packed {
    logic [31:0] stat_count;
    logic [31:0] stat_sum;
    logic [15:0] stat_min;
    logic [15:0] stat_max;
    logic [31:0] event_total;
  } elsm_rsp_t;

  // One sample headed for an accumulator, unclamped
  typedef struct packed {
    logic        en;
    acc_idx_t    idx;
    logic [31:0] ms;
  } elsm_sample_t;

  // Read data of one accumulator
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] sum;
    logic [15:0] min;
    logic [15:0] max;
  } elsm_acc_rd_t;

endpackage

// ----- hw/rtl/elsm_req_if.sv -----
// ============================================================================
// elsm_req_if
// Valid/ready channel that carries one monitor event per beat.
// ============================================================================
interface elsm_req_if
  import elsm_pkg::*;
;
  logic      valid;
  logic      ready;
  elsm_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/elsm_rsp_if.sv -----
// ============================================================================
// elsm_rsp_if
// Valid/ready channel that carries one statistics result per beat.
// ============================================================================
interface elsm_rsp_if
  import elsm_pkg::*;
;
  logic      valid;
  logic      ready;
  elsm_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/elsm_acc_bank.sv -----
// ============================================================================
// elsm_acc_bank
// Seven count/sum/min/max accumulators with two sample ports and a clear.
// ============================================================================
module elsm_acc_bank
  import elsm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clear_i,
  input  elsm_sample_t smp_a_i,
  input  elsm_sample_t smp_b_i,
  input  acc_idx_t     rd_idx_i,
  output elsm_acc_rd_t rd_o
);

  logic [31:0] count_q [NumAcc];
  logic [31:0] sum_q   [NumAcc];
  logic [15:0] min_q   [NumAcc];
  logic [15:0] max_q   [NumAcc];

  for (genvar k = 0; k < NumAcc; k++) begin : g_acc
    logic        hit_a;
    logic        hit_b;
    logic [31:0] raw_ms;
    logic [15:0] ms;

    assign hit_a  = smp_a_i.en && (smp_a_i.idx == acc_idx_t'(k));
    assign hit_b  = smp_b_i.en && (smp_b_i.idx == acc_idx_t'(k));
    assign raw_ms = hit_a ? smp_a_i.ms : smp_b_i.ms;
    assign ms     = (raw_ms > 32'(ClampMs)) ? 16'(ClampMs) : raw_ms[15:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        count_q[k] <= '0;
        sum_q[k]   <= '0;
        min_q[k]   <= '0;
        max_q[k]   <= '0;
      end else if (clear_i) begin
        count_q[k] <= '0;
        sum_q[k]   <= '0;
        min_q[k]   <= '0;
        max_q[k]   <= '0;
      end else if (hit_a || hit_b) begin
        count_q[k] <= count_q[k] + 32'd1;
        sum_q[k]   <= sum_q[k] + {16'd0, ms};
        // first sample after an empty (or wrapped) count seeds both bounds
        if (count_q[k] == '0) begin
          min_q[k] <= ms;
          max_q[k] <= ms;
        end else begin
          if (ms < min_q[k]) min_q[k] <= ms;
          if (ms > max_q[k]) max_q[k] <= ms;
        end
      end
    end
  end

  always_comb begin
    rd_o = '0;
    if (rd_idx_i < acc_idx_t'(NumAcc)) begin
      rd_o.count = count_q[rd_idx_i];
      rd_o.sum   = sum_q[rd_idx_i];
      rd_o.min   = min_q[rd_idx_i];
      rd_o.max   = max_q[rd_idx_i];
    end
  end

  for (genvar k = 0; k < NumAcc; k++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      min_q[k] <= max_q[k])
      else $error("accumulator min above max");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      max_q[k] <= 16'(ClampMs))
      else $error("accumulator max above clamp");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      clear_i |=> (count_q[k] == '0) && (sum_q[k] == '0))
      else $error("clear left an accumulator nonzero");
  end

endmodule

// ----- hw/rtl/event_latency_statistics_monitor.sv -----
// ============================================================================
// event_latency_statistics_monitor
// Latency probe: start/end event pairs and buffer levels feed min/max/sum/count statistics.
// ============================================================================
// Usage:
//   req_i carries one timestamped event per beat; rsp_o returns exactly one
//   result beat per event, in order. Only a read event returns data; every
//   other event returns an all-zero result.
//   An accepted event sits in an input register; once the output register
//   is free or being emptied, it updates stamps, pending bits, counters
//   and the accumulator bank and its result is loaded into the output
//   register. Throughput is one event per cycle while the receiver does
//   not stall; a receive-put event updates two accumulators at once.
//   When the receiver stalls, the result holds and one more event is still
//   taken into the input register; req_i.ready then drops until the result
//   is taken.
//   Reset clears all accumulators, start stamps, pending bits and counters;
//   the block accepts events in the first cycle after reset. A clear event
//   zeroes everything except the start stamps.
// ============================================================================
module event_latency_statistics_monitor
  import elsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  elsm_req_if.sink   req_i,
  elsm_rsp_if.source rsp_o
);

  elsm_req_t req_q;
  logic      req_vld_q;
  elsm_rsp_t rsp_q, rsp_d;
  logic      rsp_vld_q;
  logic      advance;
  logic      proc;

  logic [31:0]        stamp_q [NumStamp];
  logic [31:0]        stamp_d [NumStamp];
  logic [NumPend-1:0] pend_q, pend_d;
  logic [31:0]        cnt_q [NumCnt];
  logic [31:0]        cnt_d [NumCnt];

  elsm_req_e    req;
  slot_idx_t    slot;
  logic [31:0]  elapsed;
  elsm_sample_t smp_a, smp_b;
  logic         clear;
  elsm_acc_rd_t acc_rd;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign advance     = !rsp_vld_q || rsp_o.ready;
  assign proc        = req_vld_q && advance;
  assign req_i.ready = !req_vld_q || advance;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) req_vld_q <= req_i.valid;
      if (advance)     rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) req_q <= req_i.payload;
    if (proc)                       rsp_q <= rsp_d;
  end

  // --------------------------------------------------------------------------
  // Sample selection
  // --------------------------------------------------------------------------
  assign req = elsm_req_e'(req_q.req_type);

  always_comb begin
    case (req)
      REQ_SEND_BEGIN: slot = SlotCapture;
      REQ_BT_SENT:    slot = SlotExtraQ;
      REQ_TX_HANDLED: slot = SlotExtraBt;
      REQ_CMD_DONE:   slot = SlotCmdQ;
      default:        slot = SlotRecv;
    endcase
  end

  // tick difference wraps mod 2^32
  assign elapsed = (req_q.now_ticks - stamp_q[slot]) >> TickShift;

  always_comb begin
    smp_a     = '0;
    smp_a.ms  = elapsed;
    smp_b     = '0;
    smp_b.ms  = req_q.buffer_bytes >> ByteShift;
    smp_b.idx = AccRxBuf;
    clear     = 1'b0;
    if (proc) begin
      case (req)
        REQ_SEND_BEGIN: begin
          smp_a.en  = pend_q[SlotCapture[1:0]];
          smp_a.idx = AccCapSend;
        end
        REQ_BT_SENT: begin
          smp_a.en  = pend_q[SlotExtraQ[1:0]];
          smp_a.idx = AccExtraBt;
        end
        REQ_TX_HANDLED: begin
          smp_a.en  = pend_q[SlotExtraBt[1:0]];
          smp_a.idx = AccBtTx;
        end
        REQ_CMD_DONE: begin
          smp_a.en  = pend_q[SlotCmdQ[1:0]];
          smp_a.idx = AccCmd;
        end
        REQ_RECV_PUT: begin
          smp_a.en  = 1'b1;
          smp_a.idx = AccRecvPut;
          smp_b.en  = 1'b1;
        end
        REQ_PLAY_OK: begin
          smp_b.en  = 1'b1;
          smp_b.idx = AccPlayBuf;
        end
        REQ_CLEAR: clear = 1'b1;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stamps, pending bits and event counters
  // --------------------------------------------------------------------------
  always_comb begin
    stamp_d = stamp_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    if (proc) begin
      case (req)
        REQ_CAPTURE_DONE: begin
          stamp_d[SlotCapture]      = req_q.now_ticks;
          pend_d[SlotCapture[1:0]]  = 1'b1;
        end
        REQ_SEND_BEGIN: begin
          pend_d[SlotCapture[1:0]] = 1'b0;
          if (req_q.event_flag) begin
            cnt_d[CntExtra] = cnt_q[CntExtra] + 32'd1;
          end else begin
            cnt_d[CntCmd]          = cnt_q[CntCmd] + 32'd1;
            stamp_d[SlotCmdQ]      = req_q.now_ticks;
            pend_d[SlotCmdQ[1:0]]  = 1'b1;
          end
        end
        REQ_EXTRA_QUEUED: begin
          stamp_d[SlotExtraQ]     = req_q.now_ticks;
          pend_d[SlotExtraQ[1:0]] = 1'b1;
        end
        REQ_BT_SENT: begin
          pend_d[SlotExtraQ[1:0]] = 1'b0;
          if (req_q.event_flag) begin
            stamp_d[SlotExtraBt]     = req_q.now_ticks;
            pend_d[SlotExtraBt[1:0]] = 1'b1;
          end else begin
            // failed send: drop the bt interval
            cnt_d[CntTxFail]         = cnt_q[CntTxFail] + 32'd1;
            pend_d[SlotExtraBt[1:0]] = 1'b0;
          end
        end
        REQ_TX_HANDLED: pend_d[SlotExtraBt[1:0]] = 1'b0;
        REQ_CMD_DONE:   pend_d[SlotCmdQ[1:0]]    = 1'b0;
        REQ_RECV_BEGIN: stamp_d[SlotRecv]         = req_q.now_ticks;
        REQ_UNDERRUN:   cnt_d[CntUnderrun] = cnt_q[CntUnderrun] + 32'd1;
        REQ_CLEAR: begin
          pend_d = '0;
          for (int i = 0; i < NumCnt; i++) cnt_d[i] = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      for (int i = 0; i < NumStamp; i++) stamp_q[i] <= '0;
      for (int i = 0; i < NumCnt; i++)   cnt_q[i]   <= '0;
    end else begin
      pend_q  <= pend_d;
      stamp_q <= stamp_d;
      cnt_q   <= cnt_d;
    end
  end

  elsm_acc_bank u_acc_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear),
    .smp_a_i  (smp_a),
    .smp_b_i  (smp_b),
    .rd_idx_i (req_q.stat_index[2:0]),
    .rd_o     (acc_rd)
  );

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_d = '0;
    if (req == REQ_READ) begin
      if (req_q.stat_index inside {[4'd0:ReadAccLast]}) begin
        rsp_d.stat_count = acc_rd.count;
        rsp_d.stat_sum   = acc_rd.sum;
        rsp_d.stat_min   = acc_rd.min;
        rsp_d.stat_max   = acc_rd.max;
      end else if (req_q.stat_index inside {[ReadCntBase:ReadCntLast]}) begin
        rsp_d.event_total = cnt_q[cnt_idx_t'(req_q.stat_index - ReadCntBase)];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (req == REQ_CLEAR) |=> (pend_q == '0) && (cnt_q[CntExtra] == '0))
    else $error("clear left pending bits or counters set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (req != REQ_READ) |=> rsp_vld_q && (rsp_q == '0))
    else $error("non-read event returned nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(req_vld_q))
    else $error("result appeared without a held event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_q && rsp_vld_q && !rsp_o.ready |-> !req_i.ready)
    else $error("input taken while both stages full and stalled");

endmodule

// ----- tb/elsm_stats_checker.sv -----
// ============================================================================
// elsm_stats_checker
// Watches both channels of the latency monitor. Every accepted event is run
// through a local copy of the accumulators, stamps, pending bits and
// counters. The result it predicts is queued. Each result beat is compared
// field by field with the oldest queued prediction.
// ============================================================================
module elsm_stats_checker
  import elsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  elsm_req_if         req_i,
  elsm_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  logic [31:0]        acc_count   [NumAcc];
  logic [31:0]        acc_sum     [NumAcc];
  logic [15:0]        acc_min     [NumAcc];
  logic [15:0]        acc_max     [NumAcc];
  logic [31:0]        start_tick  [NumStamp];
  logic [NumPend-1:0] open_span;
  logic [31:0]        event_tally [NumCnt];

  elsm_rsp_t   stats_due_q [$];
  int unsigned mismatches;

  function void clear_stats();
    for (int k = 0; k < NumAcc; k++) begin
      acc_count[k] = '0;
      acc_sum[k]   = '0;
      acc_min[k]   = '0;
      acc_max[k]   = '0;
    end
    for (int c = 0; c < NumCnt; c++) begin
      event_tally[c] = '0;
    end
    open_span = '0;
  endfunction

  function void add_sample(acc_idx_t k, logic [31:0] ms);
    logic [31:0] clamped;
    clamped = (ms > ClampMs) ? ClampMs : ms;
    // first sample after an empty count seeds both extremes
    if (acc_count[k] == '0) begin
      acc_min[k] = clamped[15:0];
      acc_max[k] = clamped[15:0];
    end else begin
      if (clamped[15:0] < acc_min[k]) acc_min[k] = clamped[15:0];
      if (clamped[15:0] > acc_max[k]) acc_max[k] = clamped[15:0];
    end
    acc_count[k] = acc_count[k] + 32'd1;
    acc_sum[k]   = acc_sum[k] + clamped;
  endfunction

  function logic [31:0] span_ms(logic [31:0] now, slot_idx_t s);
    logic [31:0] ticks;
    ticks = now - start_tick[s];
    return ticks / TicksPerMs;
  endfunction

  function void close_span(logic [31:0] now, slot_idx_t s, acc_idx_t k);
    if (open_span[s]) begin
      add_sample(k, span_ms(now, s));
      open_span[s] = 1'b0;
    end
  endfunction

  function void open_span_at(logic [31:0] now, slot_idx_t s);
    start_tick[s] = now;
    open_span[s]  = 1'b1;
  endfunction

  function elsm_rsp_t predict_result(elsm_req_t ev);
    elsm_rsp_t  res;
    logic [3:0] idx;
    res = '0;
    idx = ev.stat_index;
    case (ev.req_type)
      REQ_CAPTURE_DONE: open_span_at(ev.now_ticks, SlotCapture);
      REQ_SEND_BEGIN: begin
        close_span(ev.now_ticks, SlotCapture, AccCapSend);
        if (ev.event_flag) begin
          event_tally[CntExtra] = event_tally[CntExtra] + 32'd1;
        end else begin
          event_tally[CntCmd] = event_tally[CntCmd] + 32'd1;
          open_span_at(ev.now_ticks, SlotCmdQ);
        end
      end
      REQ_EXTRA_QUEUED: open_span_at(ev.now_ticks, SlotExtraQ);
      REQ_BT_SENT: begin
        close_span(ev.now_ticks, SlotExtraQ, AccExtraBt);
        if (ev.event_flag) begin
          open_span_at(ev.now_ticks, SlotExtraBt);
        end else begin
          // failed send: drop the bt interval
          event_tally[CntTxFail] = event_tally[CntTxFail] + 32'd1;
          open_span[SlotExtraBt] = 1'b0;
        end
      end
      REQ_TX_HANDLED: close_span(ev.now_ticks, SlotExtraBt, AccBtTx);
      REQ_CMD_DONE:   close_span(ev.now_ticks, SlotCmdQ, AccCmd);
      REQ_RECV_BEGIN: start_tick[SlotRecv] = ev.now_ticks;
      REQ_RECV_PUT: begin
        // no pending bit on recv: always measure from the stored stamp
        add_sample(AccRecvPut, span_ms(ev.now_ticks, SlotRecv));
        add_sample(AccRxBuf, ev.buffer_bytes / BytesPerMs);
      end
      REQ_PLAY_OK:  add_sample(AccPlayBuf, ev.buffer_bytes / BytesPerMs);
      REQ_UNDERRUN: event_tally[CntUnderrun] = event_tally[CntUnderrun] + 32'd1;
      REQ_CLEAR:    clear_stats();
      REQ_READ: begin
        if (idx <= ReadAccLast) begin
          res.stat_count = acc_count[idx];
          res.stat_sum   = acc_sum[idx];
          res.stat_min   = acc_min[idx];
          res.stat_max   = acc_max[idx];
        end else if (idx <= ReadCntLast) begin
          res.event_total = event_tally[cnt_idx_t'(idx - ReadCntBase)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    elsm_rsp_t want;
    elsm_rsp_t got;
    logic [4:0] bad;
    if (!rst_ni) begin
      clear_stats();
      for (int s = 0; s < NumStamp; s++) begin
        start_tick[s] = '0;
      end
      stats_due_q.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      results_due_o <= 0;
    end else begin
      got = rsp_i.payload;
      if (rsp_i.valid && rsp_i.ready) begin
        if (stats_due_q.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("[%0t] result beat with nothing expected: count %0d sum %0d",
                     $time, got.stat_count, got.stat_sum);
          end
          mismatches++;
        end else begin
          want = stats_due_q.pop_front();
          bad = {got.stat_count  !== want.stat_count,
                 got.stat_sum    !== want.stat_sum,
                 got.stat_min    !== want.stat_min,
                 got.stat_max    !== want.stat_max,
                 got.event_total !== want.event_total};
          if (|bad) begin
            if (mismatches < ReportLimit) begin
              $display("[%0t] result mismatch (count,sum,min,max,total = %b)", $time, bad);
              $display("  expected: count %0d sum %0d min %0d max %0d total %0d",
                       want.stat_count, want.stat_sum, want.stat_min, want.stat_max,
                       want.event_total);
              $display("  actual:   count %0d sum %0d min %0d max %0d total %0d",
                       got.stat_count, got.stat_sum, got.stat_min, got.stat_max,
                       got.event_total);
            end
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        stats_due_q.push_back(predict_result(req_i.payload));
      end
      fail_count_o  <= mismatches;
      results_due_o <= stats_due_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top
// Stimulus and verdict for the event latency statistics monitor. A directed
// pass hits wraparound, clamping, orphan end events, unused codes and
// out-of-range reads. Random phases then run mostly well-formed start/end
// sequences with random timing under varied sender idling and receiver
// stalls. The checker beside the block does all prediction and comparison.
// ============================================================================
module tb_top
  import elsm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned EndLatency = 8;
  localparam int unsigned PhaseItems = 450;
  localparam logic [3:0]  ReqUnusedLo = 4'd12;
  localparam logic [3:0]  ReqUnusedHi = 4'd15;
  localparam logic [3:0]  ReadIdxTop  = 4'd15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned results_due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned events_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] tick_now = '0;

  elsm_req_if req_ch ();
  elsm_rsp_if rsp_ch ();

  event_latency_statistics_monitor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  elsm_stats_checker stats_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("** event_latency_statistics_monitor: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic elsm_req_t timed_event(logic [3:0] code);
    elsm_req_t ev;
    ev.req_type     = code;
    ev.now_ticks    = tick_now;
    ev.event_flag   = 1'($urandom_range(1));
    ev.buffer_bytes = $urandom;
    ev.stat_index   = 4'($urandom_range(15));
    return ev;
  endfunction

  function automatic void advance_clock();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)      tick_now += $urandom_range(31);
    else if (r < 70) tick_now += $urandom_range(TicksPerMs * 3000);
    else if (r < 90) tick_now += $urandom_range(TicksPerMs * 70000);
    else             tick_now += $urandom;
  endfunction

  function automatic logic [31:0] buffer_fill();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80)      return $urandom_range(BytesPerMs * 5000);
    else if (r < 95) return $urandom_range(BytesPerMs * 70000);
    else             return $urandom;
  endfunction

  task automatic send_event(input elsm_req_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= ev;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic read_stat(input logic [3:0] idx);
    elsm_req_t ev;
    ev = timed_event(REQ_READ);
    ev.stat_index = idx;
    send_event(ev);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    elsm_req_t   ev;
    int unsigned stop_at;
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = events_sent + n_items;
    while (events_sent < stop_at) begin
      pick = $urandom_range(99);
      advance_clock();
      if (pick < 14) begin
        send_event(timed_event(REQ_CAPTURE_DONE));
        advance_clock();
        send_event(timed_event(REQ_SEND_BEGIN));
      end else if (pick < 22) begin
        send_event(timed_event(REQ_CMD_DONE));
      end else if (pick < 36) begin
        send_event(timed_event(REQ_EXTRA_QUEUED));
        advance_clock();
        ev = timed_event(REQ_BT_SENT);
        ev.event_flag = ($urandom_range(3) != 0);
        send_event(ev);
        if ($urandom_range(4) != 0) begin
          advance_clock();
          send_event(timed_event(REQ_TX_HANDLED));
        end
      end else if (pick < 46) begin
        send_event(timed_event(REQ_RECV_BEGIN));
        repeat ($urandom_range(1, 3)) begin
          advance_clock();
          ev = timed_event(REQ_RECV_PUT);
          ev.buffer_bytes = buffer_fill();
          send_event(ev);
        end
      end else if (pick < 54) begin
        ev = timed_event(REQ_PLAY_OK);
        ev.buffer_bytes = buffer_fill();
        send_event(ev);
      end else if (pick < 57) begin
        send_event(timed_event(REQ_UNDERRUN));
      end else if (pick < 86) begin
        if ($urandom_range(9) != 0) read_stat(4'($urandom_range(ReadCntLast)));
        else                        read_stat(4'($urandom_range(ReadIdxTop, ReadCntLast + 1)));
      end else if (pick < 87) begin
        send_event(timed_event(REQ_CLEAR));
      end else if (pick < 95) begin
        // lone event of any code up to underrun, out of sequence
        send_event(timed_event(4'($urandom_range(REQ_UNDERRUN))));
      end else begin
        tick_now = $urandom;
        send_event(timed_event(4'($urandom_range(15))));
      end
    end
  endtask

  initial begin
    elsm_req_t ev;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty reads, orphan ends, wrap, clamp, every event code
    read_stat(4'(AccCapSend));
    read_stat(ReadIdxTop);
    send_event(timed_event(ReqUnusedLo));
    send_event(timed_event(ReqUnusedHi));
    send_event(timed_event(REQ_TX_HANDLED));
    send_event(timed_event(REQ_CMD_DONE));
    tick_now = 32'hFFFF_FFF0;
    send_event(timed_event(REQ_CAPTURE_DONE));
    tick_now = 32'h0000_0030;
    ev = timed_event(REQ_SEND_BEGIN);
    ev.event_flag = 1'b0;
    send_event(ev);
    tick_now = 32'hFFFF_FFFF;
    send_event(timed_event(REQ_CMD_DONE));
    tick_now = '0;
    send_event(timed_event(REQ_CAPTURE_DONE));
    ev = timed_event(REQ_SEND_BEGIN);
    ev.event_flag = 1'b1;
    send_event(ev);
    tick_now = 32'd100;
    send_event(timed_event(REQ_EXTRA_QUEUED));
    tick_now += TicksPerMs * 5;
    ev = timed_event(REQ_BT_SENT);
    ev.event_flag = 1'b1;
    send_event(ev);
    tick_now += TicksPerMs * 7 + 15;
    send_event(timed_event(REQ_TX_HANDLED));
    send_event(timed_event(REQ_EXTRA_QUEUED));
    tick_now += 3;
    ev = timed_event(REQ_BT_SENT);
    ev.event_flag = 1'b0;
    send_event(ev);
    send_event(timed_event(REQ_TX_HANDLED));
    send_event(timed_event(REQ_RECV_BEGIN));
    tick_now += TicksPerMs * 3;
    ev = timed_event(REQ_RECV_PUT);
    ev.buffer_bytes = 32'hFFFF_FFFF;
    send_event(ev);
    ev = timed_event(REQ_PLAY_OK);
    ev.buffer_bytes = '0;
    send_event(ev);
    send_event(timed_event(REQ_UNDERRUN));
    read_stat(4'(AccExtraBt));
    read_stat(4'(AccBtTx));
    read_stat(4'(AccRxBuf));
    read_stat(4'(AccPlayBuf));
    read_stat(ReadCntBase + CntCmd);
    read_stat(ReadCntBase + CntTxFail);
    send_event(timed_event(REQ_CLEAR));
    read_stat(4'(AccRxBuf));
    read_stat(ReadCntBase + CntUnderrun);
    drain_results();

    run_phase(PhaseItems, 0, 0);
    drain_results();
    run_phase(PhaseItems, 55, 0);
    drain_results();
    run_phase(PhaseItems, 0, 55);
    drain_results();
    run_phase(PhaseItems, 36, 36);
    drain_results();
    repeat (EndLatency) @(posedge clk_i);

    if (fail_count == 0 && results_due == 0) begin
      $display("** event_latency_statistics_monitor: PASSED **");
    end else begin
      $display("** event_latency_statistics_monitor: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/elsm_pkg.sv
hw/rtl/elsm_req_if.sv
hw/rtl/elsm_rsp_if.sv
hw/rtl/elsm_acc_bank.sv
hw/rtl/event_latency_statistics_monitor.sv
tb/elsm_stats_checker.sv
tb/tb_top.sv
